>>> rtl/ctcc_pkg.sv
// Shared types, codes and constant tables of the Crofton threshold cube counter.
package ctcc_pkg;

   localparam int CORNERS        = 8;
   localparam int LANES          = 4;
   localparam int BIN_FIELD_BITS = 6;
   localparam int BIN_WIDE_BITS  = 9;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int DELTA_BITS     = 4;

   localparam logic [CORNERS-1:0] EDGE_MASKS [3] = '{8'h03, 8'h05, 8'h11};
   localparam logic [CORNERS-1:0] FACE_MASKS [3] = '{8'h0F, 8'h55, 8'h33};

   typedef enum logic [1:0] {
      OP_ACCUMULATE = 2'd0,
      OP_READ       = 2'd1,
      OP_CLEAR      = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_THRESHOLD_LOW  = 2'd0,
      CSR_THRESHOLD_STEP = 2'd1,
      CSR_BIN_COUNT      = 2'd2
   } csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_READ
   } state_type;

   typedef struct packed {
      logic signed [DELTA_BITS-1:0] volume;
      logic signed [DELTA_BITS-1:0] surface;
      logic signed [DELTA_BITS-1:0] curvature;
      logic signed [DELTA_BITS-1:0] euler;
   } delta_type;

endpackage

>>> rtl/ctcc_req_if.sv
// Request channel carrying one cube, read or clear command.
interface ctcc_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    operation;
   logic signed [SAMPLE_BITS-1:0] corner0;
   logic signed [SAMPLE_BITS-1:0] corner1;
   logic signed [SAMPLE_BITS-1:0] corner2;
   logic signed [SAMPLE_BITS-1:0] corner3;
   logic signed [SAMPLE_BITS-1:0] corner4;
   logic signed [SAMPLE_BITS-1:0] corner5;
   logic signed [SAMPLE_BITS-1:0] corner6;
   logic signed [SAMPLE_BITS-1:0] corner7;
   logic [5:0]                    read_bin;

   modport source (output valid, operation, corner0, corner1, corner2, corner3,
                   corner4, corner5, corner6, corner7, read_bin, input ready);
   modport sink   (input valid, operation, corner0, corner1, corner2, corner3,
                   corner4, corner5, corner6, corner7, read_bin, output ready);
endinterface

>>> rtl/ctcc_rsp_if.sv
// Response channel carrying the sums of one threshold bin.
interface ctcc_rsp_if #(
   parameter int SUM_BITS = 40
);
   logic                       valid;
   logic                       ready;
   logic [5:0]                 bin_index;
   logic signed [SUM_BITS-1:0] volume_sum;
   logic signed [SUM_BITS-1:0] surface_sum;
   logic signed [SUM_BITS-1:0] curvature_sum;
   logic signed [SUM_BITS-1:0] euler_sum;
   logic                       saturated;

   modport source (output valid, bin_index, volume_sum, surface_sum, curvature_sum,
                   euler_sum, saturated, input ready);
   modport sink   (input valid, bin_index, volume_sum, surface_sum, curvature_sum,
                   euler_sum, saturated, output ready);
endinterface

>>> rtl/crofton_threshold_cube_counter_unit.sv
// Top level of the Crofton threshold cube counter: sequencer, registers and result stage.
//
// An accumulate request sweeps thresholds 0 to min(bin_count, THRESHOLD_BINS-1), reading
// one bin row of the accumulator store per cycle and writing it back in the cycle after
// its read. A read request returns its result through an output register, and a clear
// wipes the store at once through per-row valid bits; no clearing pass is needed after
// reset.
module crofton_threshold_cube_counter_unit import ctcc_pkg::*; #(
   parameter int THRESHOLD_BINS = 64,
   parameter int SAMPLE_BITS    = 16,
   parameter int SUM_BITS       = 40
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   ctcc_req_if.sink                  req_channel,
   ctcc_rsp_if.source                rsp_channel
);

   localparam int IDX_BITS = (THRESHOLD_BINS > 1) ? $clog2(THRESHOLD_BINS) : 1;
   localparam int THR_BITS = ((SAMPLE_BITS > CSR_DATA_BITS) ? SAMPLE_BITS : CSR_DATA_BITS)
                             + 10;
   localparam int ROW_BITS = LANES * SUM_BITS + 1;

   state_type state_ff, state_in;

   logic [CSR_DATA_BITS-1:0]  low_ff;
   logic [CSR_DATA_BITS-1:0]  step_ff;
   logic [BIN_FIELD_BITS-1:0] count_ff;

   logic [CORNERS-1:0][SAMPLE_BITS-1:0] samples_ff;
   logic signed [THR_BITS-1:0]          t_ff;
   logic [IDX_BITS-1:0]                 bin_ff;
   logic [IDX_BITS-1:0]                 last_ff;
   logic                                pend_valid_ff;
   logic [IDX_BITS-1:0]                 pend_addr_ff;
   delta_type                           delta_ff;
   logic                                rd_zero_ff;
   logic [BIN_FIELD_BITS-1:0]           read_bin_ff;

   logic                                rsp_valid_ff;
   logic [BIN_FIELD_BITS-1:0]           rsp_bin_ff;
   logic [LANES-1:0][SUM_BITS-1:0]      rsp_sums_ff;
   logic                                rsp_sat_ff;

   logic                           req_ready;
   logic                           req_fire;
   op_type                         op;
   logic                           sweep_issue;
   logic                           rsp_load;
   logic                           store_clear;
   logic                           rd_en;
   logic [IDX_BITS-1:0]            rd_addr;
   logic [ROW_BITS-1:0]            rd_row;
   logic [ROW_BITS-1:0]            wr_row;
   logic [LANES-1:0][SUM_BITS-1:0] sums_new;
   logic                           sat_new;
   delta_type                      delta;

   logic [BIN_WIDE_BITS-1:0]       count_wide;
   logic [BIN_WIDE_BITS-1:0]       last_wide;
   logic [BIN_WIDE_BITS-1:0]       read_wide;
   logic                           read_in_range;
   logic [SAMPLE_BITS-1:0]         low_sample;
   logic [CORNERS-1:0][SAMPLE_BITS-1:0] corners;

   assign op          = op_type'(req_channel.operation);
   assign req_fire    = req_channel.valid && req_ready;
   assign req_channel.ready = req_ready;

   assign count_wide    = {{(BIN_WIDE_BITS-BIN_FIELD_BITS){1'b0}}, count_ff};
   assign last_wide     = (count_wide > BIN_WIDE_BITS'(THRESHOLD_BINS - 1))
                          ? BIN_WIDE_BITS'(THRESHOLD_BINS - 1) : count_wide;
   assign read_wide     = {{(BIN_WIDE_BITS-BIN_FIELD_BITS){1'b0}}, req_channel.read_bin};
   assign read_in_range = read_wide < BIN_WIDE_BITS'(THRESHOLD_BINS);
   assign low_sample    = SAMPLE_BITS'(low_ff);

   assign corners = {req_channel.corner7, req_channel.corner6, req_channel.corner5,
                     req_channel.corner4, req_channel.corner3, req_channel.corner2,
                     req_channel.corner1, req_channel.corner0};

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff   <= '0;
         step_ff  <= CSR_DATA_BITS'(1);
         count_ff <= BIN_FIELD_BITS'(63);
      end else if (csr_write) begin
         case (csr_index)
            CSR_THRESHOLD_LOW:  low_ff   <= csr_data;
            CSR_THRESHOLD_STEP: step_ff  <= csr_data;
            CSR_BIN_COUNT:      count_ff <= csr_data[BIN_FIELD_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && op == OP_ACCUMULATE) begin
               state_in = ST_SWEEP;
            end else if (req_fire && op == OP_READ) begin
               state_in = ST_READ;
            end
         end
         ST_SWEEP: begin
            if (bin_ff == last_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (!rsp_valid_ff || rsp_channel.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // The last write-back of a sweep must land before the next request touches the store.
   always_comb begin
      req_ready   = 1'b0;
      sweep_issue = 1'b0;
      rsp_load    = 1'b0;
      store_clear = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = bin_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = !pend_valid_ff;
            rd_en       = req_fire && op == OP_READ;
            rd_addr     = read_wide[IDX_BITS-1:0];
            store_clear = req_fire && op == OP_CLEAR;
         end
         ST_SWEEP: begin
            sweep_issue = 1'b1;
            rd_en       = 1'b1;
         end
         ST_READ: begin
            rsp_load = !rsp_valid_ff || rsp_channel.ready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= sweep_issue;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_channel.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && op == OP_ACCUMULATE) begin
         samples_ff <= corners;
         t_ff       <= THR_BITS'(signed'(low_sample));
         bin_ff     <= '0;
         last_ff    <= last_wide[IDX_BITS-1:0];
      end else if (sweep_issue) begin
         bin_ff <= bin_ff + IDX_BITS'(1);
         t_ff   <= t_ff + THR_BITS'(step_ff);
      end
      if (req_fire && op == OP_READ) begin
         rd_zero_ff  <= !read_in_range;
         read_bin_ff <= req_channel.read_bin;
      end
      if (sweep_issue) begin
         delta_ff     <= delta;
         pend_addr_ff <= bin_ff;
      end
      if (rsp_load) begin
         rsp_bin_ff  <= read_bin_ff;
         rsp_sums_ff <= rd_zero_ff ? '0 : rd_row[LANES*SUM_BITS-1:0];
         rsp_sat_ff  <= !rd_zero_ff && rd_row[ROW_BITS-1];
      end
   end

   ctcc_cube_eval #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .THR_BITS    (THR_BITS)
   ) u_eval (
      .samples   (samples_ff),
      .threshold (t_ff),
      .delta     (delta)
   );

   ctcc_sat_add #(
      .SUM_BITS (SUM_BITS)
   ) u_add (
      .sums_in  (rd_row[LANES*SUM_BITS-1:0]),
      .sat_in   (rd_row[ROW_BITS-1]),
      .delta    (delta_ff),
      .sums_out (sums_new),
      .sat_out  (sat_new)
   );

   assign wr_row = {sat_new, sums_new};

   ctcc_store #(
      .DEPTH    (THRESHOLD_BINS),
      .ROW_BITS (ROW_BITS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .clear   (store_clear),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_row  (rd_row),
      .wr_en   (pend_valid_ff),
      .wr_addr (pend_addr_ff),
      .wr_row  (wr_row)
   );

   assign rsp_channel.valid         = rsp_valid_ff;
   assign rsp_channel.bin_index     = rsp_bin_ff;
   assign rsp_channel.volume_sum    = rsp_sums_ff[0];
   assign rsp_channel.surface_sum   = rsp_sums_ff[1];
   assign rsp_channel.curvature_sum = rsp_sums_ff[2];
   assign rsp_channel.euler_sum     = rsp_sums_ff[3];
   assign rsp_channel.saturated     = rsp_sat_ff;

   // A write-back only ever follows a sweep cycle.
   a_write_after_sweep: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> $past(state_ff == ST_SWEEP))
      else $error("Store write-back without a preceding sweep read.");

   // No request is taken while a write-back is outstanding.
   a_ready_interlock: assert property (@(posedge clock) disable iff (reset)
      req_channel.ready |-> !pend_valid_ff && state_ff == ST_IDLE)
      else $error("Request accepted while the store is busy.");

   // The sweep never runs past the last bin in use.
   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SWEEP |-> bin_ff <= last_ff)
      else $error("Threshold sweep overran its last bin.");

endmodule

>>> rtl/ctcc_store.sv
// Accumulator store: one row per threshold bin, registered read, per-row valid bits.
module ctcc_store #(
   parameter int  DEPTH     = 64,
   parameter int  ROW_BITS  = 161,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [ROW_BITS-1:0]  rd_row,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [ROW_BITS-1:0]  wr_row
);

   logic [ROW_BITS-1:0] mem [DEPTH];
   logic [ROW_BITS-1:0] rd_data_ff;
   logic [DEPTH-1:0]    valid_ff;
   logic                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // A row that has not been written since reset or the last clear reads as zero.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

endmodule

>>> rtl/ctcc_cube_eval.sv
// Occupancy of the eight corners against one threshold and the four Crofton increments.
module ctcc_cube_eval import ctcc_pkg::*; #(
   parameter int SAMPLE_BITS = 16,
   parameter int THR_BITS    = 26
) (
   input  logic [CORNERS-1:0][SAMPLE_BITS-1:0] samples,
   input  logic signed [THR_BITS-1:0]          threshold,
   output delta_type                           delta
);

   logic [CORNERS-1:0] occ;
   logic [1:0]         n2;
   logic [1:0]         n1;

   always_comb begin
      for (int i = 0; i < CORNERS; i++) begin
         occ[i] = THR_BITS'(signed'(samples[i])) > threshold;
      end
   end

   always_comb begin
      n2 = 2'd0;
      n1 = 2'd0;
      for (int k = 0; k < 3; k++) begin
         n2 = n2 + 2'((|(occ & EDGE_MASKS[k])) ? 1 : 0);
         n1 = n1 + 2'((|(occ & FACE_MASKS[k])) ? 1 : 0);
      end
   end

   always_comb begin
      logic signed [DELTA_BITS-1:0] s3;
      logic signed [DELTA_BITS-1:0] s2;
      logic signed [DELTA_BITS-1:0] s1;
      logic signed [DELTA_BITS-1:0] s0;
      s3 = signed'({3'b000, occ[0]});
      s2 = signed'({2'b00, n2});
      s1 = signed'({2'b00, n1});
      s0 = signed'({3'b000, |occ});
      delta.volume    = s3;
      delta.surface   = s2 - 4'sd3 * s3;
      delta.curvature = 4'sd3 * s3 - 4'sd2 * s2 + s1;
      delta.euler     = s2 - s3 - s1 + s0;
   end

endmodule

>>> rtl/ctcc_sat_add.sv
// Saturating update of the four sums of one bin and its saturation mark.
module ctcc_sat_add import ctcc_pkg::*; #(
   parameter int SUM_BITS = 40
) (
   input  logic [LANES-1:0][SUM_BITS-1:0] sums_in,
   input  logic                           sat_in,
   input  delta_type                      delta,
   output logic [LANES-1:0][SUM_BITS-1:0] sums_out,
   output logic                           sat_out
);

   logic signed [LANES-1:0][DELTA_BITS-1:0] d;
   logic [LANES-1:0]                        clamp;

   assign d[0] = delta.volume;
   assign d[1] = delta.surface;
   assign d[2] = delta.curvature;
   assign d[3] = delta.euler;

   always_comb begin
      logic signed [SUM_BITS:0] s;
      for (int k = 0; k < LANES; k++) begin
         s = signed'({sums_in[k][SUM_BITS-1], sums_in[k]})
             + (SUM_BITS+1)'(signed'(d[k]));
         clamp[k] = s[SUM_BITS] != s[SUM_BITS-1];
         if (!clamp[k]) begin
            sums_out[k] = s[SUM_BITS-1:0];
         end else if (s[SUM_BITS]) begin
            sums_out[k] = {1'b1, {(SUM_BITS-1){1'b0}}};
         end else begin
            sums_out[k] = {1'b0, {(SUM_BITS-1){1'b1}}};
         end
      end
   end

   assign sat_out = sat_in | (|clamp);

endmodule
